@@ rtl/core/fss_pkg.sv @@
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, codes and helpers of the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

    // query storage and score format
    localparam int QBYTES     = 32;
    localparam int FRAC_BITS  = 16;
    localparam logic [16:0] SCORE_ONE = 17'h10000;

    // configuration register indexes
    localparam logic [2:0] CFG_QLEN = 3'd0;
    localparam logic [2:0] CFG_QA   = 3'd1;
    localparam logic [2:0] CFG_QB   = 3'd2;
    localparam logic [2:0] CFG_QC   = 3'd3;
    localparam logic [2:0] CFG_QD   = 3'd4;

    // multiplier operand a
    typedef logic [2:0] t_asel;
    localparam t_asel A_LM   = 3'd0;
    localparam t_asel A_RM   = 3'd1;
    localparam t_asel A_CL   = 3'd2;
    localparam t_asel A_SM   = 3'd3;
    localparam t_asel A_PROD = 3'd4;

    // multiplier operand b
    typedef logic t_bsel;
    localparam t_bsel B_GD = 1'b0;
    localparam t_bsel B_T  = 1'b1;

    // accumulator operation on the previous product
    typedef logic [2:0] t_accop;
    localparam t_accop ACC_NONE  = 3'd0;
    localparam t_accop ACC_INIT  = 3'd1;
    localparam t_accop ACC_ADD15 = 3'd2;
    localparam t_accop ACC_ADD7  = 3'd3;
    localparam t_accop ACC_ADD3  = 3'd4;
    localparam t_accop ACC_NEG   = 3'd5;

    // score sequence length
    localparam int NUM_STEPS = 9;
    localparam logic [3:0] LAST_STEP = 4'(NUM_STEPS - 1);

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        t_accop acc_op;
    } t_step;

    // controller to datapath
    typedef struct packed {
        logic   accept;
        logic   prep;
        logic   calc;
        t_step  step;
        logic   div_start;
        logic   load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_calc;
        logic div_busy;
        logic out_full;
    } t_status;

    // ascii upper to lower case
    function automatic logic [7:0] fold(input logic [7:0] ch);
        if (ch >= 8'd65 && ch <= 8'd90) begin
            return ch + 8'd32;
        end
        return ch;
    endfunction

    // score sequence: one multiply per step, accumulate the product of the step before
    function automatic t_step step_cmd(input logic [3:0] step);
        t_step s;
        s = '{a_sel: A_PROD, b_sel: B_T, acc_op: ACC_NONE};
        unique case (step)
            4'd0: s = '{a_sel: A_LM,   b_sel: B_GD, acc_op: ACC_NONE};
            4'd1: s = '{a_sel: A_PROD, b_sel: B_T,  acc_op: ACC_NONE};
            4'd2: s = '{a_sel: A_RM,   b_sel: B_GD, acc_op: ACC_INIT};
            4'd3: s = '{a_sel: A_PROD, b_sel: B_T,  acc_op: ACC_NONE};
            4'd4: s = '{a_sel: A_CL,   b_sel: B_GD, acc_op: ACC_ADD15};
            4'd5: s = '{a_sel: A_PROD, b_sel: B_T,  acc_op: ACC_NONE};
            4'd6: s = '{a_sel: A_LM,   b_sel: B_T,  acc_op: ACC_ADD7};
            4'd7: s = '{a_sel: A_SM,   b_sel: B_GD, acc_op: ACC_ADD3};
            4'd8: s = '{a_sel: A_PROD, b_sel: B_T,  acc_op: ACC_NEG};
            default: s = '{a_sel: A_PROD, b_sel: B_T, acc_op: ACC_NONE};
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/fss_div.sv @@
// ----------------------------------------------------------------------------
// fss_div
// Bit-serial fraction divider: quotient of num/den in 16 fraction bits,
// saturated to 1.0 when num >= den. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fss_div #(
    parameter int AW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_num,
    input  logic [AW-1:0] i_den,
    output logic          o_busy,
    output logic [16:0]   o_quot
);
    import fss_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic [AW-1:0] r_rem, n_rem;
    logic [16:0]   r_quot, n_quot;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW:0]   w_rem2;
    logic          w_ge;

    // shifted remainder and trial compare
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, i_den};

    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_rem = i_num;
            if (i_num >= i_den) begin
                n_quot = SCORE_ONE;
                n_cnt  = '0;
            end else begin
                n_quot = '0;
                n_cnt  = CW'(FRAC_BITS);
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (w_ge) begin
                n_rem  = AW'(w_rem2 - {1'b0, i_den});
                n_quot = {r_quot[15:0], 1'b1};
            end else begin
                n_rem  = AW'(w_rem2);
                n_quot = {r_quot[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/fss_datapath.sv @@
// ----------------------------------------------------------------------------
// fss_datapath
// Query registers, per-target match state, score arithmetic with one shared
// multiplier, the divider and the result register.
// ----------------------------------------------------------------------------
module fss_datapath #(
    parameter int MAX_QUERY  = 32,
    parameter int MAX_TARGET = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fss_pkg::t_cmd    i_cmd,
    output fss_pkg::t_status o_status,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [63:0]      i_cfg_wdata,
    input  logic [7:0]       i_char,
    input  logic             i_char_valid,
    input  logic             i_m_tready,
    output logic             o_out_valid,
    output logic             o_matched,
    output logic [16:0]      o_score,
    output logic [9:0]       o_first,
    output logic [9:0]       o_last,
    output logic             o_overflow
);
    import fss_pkg::*;

    localparam int QLIM = (MAX_QUERY < QBYTES) ? MAX_QUERY : QBYTES;
    localparam int TW   = $clog2(MAX_TARGET + 1);
    localparam int PSW  = $clog2(MAX_TARGET);
    localparam int SW   = TW + 5;
    localparam int AMW  = TW + 10;
    localparam int PW   = AMW + TW;
    localparam int AW   = PW + 6;

    // configuration
    logic [5:0]  r_qlen;
    logic [63:0] r_qa, r_qb, r_qc, r_qd;

    // per-target state
    logic [5:0]     r_qidx;
    logic [TW-1:0]  r_tpos;
    logic [5:0]     r_run;
    logic           r_open;
    logic [4:0]     r_cons;
    logic [PSW-1:0] r_prev;
    logic [PSW-1:0] r_first;
    logic [SW-1:0]  r_psum;
    logic           r_ovf;

    // score operands
    logic [9:0]     r_lm, r_rm, r_cl;
    logic [AMW-1:0] r_sm;
    logic [TW-1:0]  r_gd, r_t;
    logic           r_multi, r_zero_q, r_match, r_exact;
    logic [PW-1:0]  r_prod;
    logic [AW-1:0]  r_acc, r_den, r_num;

    // result register
    logic        r_out_valid;
    logic        r_o_matched, r_o_ovf;
    logic [16:0] r_o_score;
    logic [9:0]  r_o_first, r_o_last;

    logic [255:0]   w_qbytes;
    logic [5:0]     w_qlen;
    logic [7:0]     w_ch, w_qc_idx, w_qc_pos;
    logic           w_hit;
    logic [5:0]     w_r;
    logic [4:0]     w_m, w_lm1, w_c;
    logic           w_multi;
    logic [PSW-1:0] w_span, w_g;
    logic [TW-1:0]  w_gd;
    logic           w_match, w_exact;
    logic [AMW-1:0] w_a;
    logic [TW-1:0]  w_b;
    logic [PW-1:0]  w_prod;
    logic [AW-1:0]  w_p, w_neg;
    logic           w_div_busy;
    logic [16:0]    w_quot, w_score;
    logic           w_out_take;

    // effective query length and character selection
    assign w_qbytes = {r_qd, r_qc, r_qb, r_qa};
    assign w_qlen   = (r_qlen > 6'(QLIM)) ? 6'(QLIM) : r_qlen;
    assign w_ch     = fold(i_char);
    assign w_qc_idx = fold(w_qbytes[{r_qidx[4:0], 3'b000} +: 8]);
    assign w_qc_pos = fold(w_qbytes[{r_tpos[4:0], 3'b000} +: 8]);
    assign w_hit    = (r_qidx < w_qlen) && (w_ch == w_qc_idx);

    // score operands from the end-of-target state
    assign w_multi = w_qlen > 6'd1;
    assign w_lm1   = 5'(w_qlen - 6'd1);
    assign w_r     = (r_run < w_qlen) ? r_run : w_qlen;
    assign w_m     = w_multi ? w_lm1 : 5'd1;
    assign w_c     = w_multi ? ((r_cons < w_lm1) ? r_cons : w_lm1) : 5'd0;
    assign w_span  = r_prev - r_first;
    assign w_g     = (32'(w_span) > 32'(w_lm1)) ? PSW'(32'(w_span) - 32'(w_lm1)) : '0;
    assign w_gd    = w_multi ? TW'(w_g) + TW'(1) : TW'(1);
    assign w_match = (r_tpos != '0) && (r_qidx == w_qlen);
    assign w_exact = (32'(r_tpos) == 32'(w_qlen)) && (w_r == w_qlen);

    // shared multiplier
    always_comb begin
        unique case (i_cmd.step.a_sel)
            A_LM:    w_a = AMW'(r_lm);
            A_RM:    w_a = AMW'(r_rm);
            A_CL:    w_a = AMW'(r_cl);
            A_SM:    w_a = r_sm;
            A_PROD:  w_a = r_prod[AMW-1:0];
            default: w_a = '0;
        endcase
    end
    assign w_b    = (i_cmd.step.b_sel == B_GD) ? r_gd : r_t;
    assign w_prod = w_a * w_b;
    assign w_p    = AW'(r_prod);
    assign w_neg  = w_p * AW'(5);

    fss_div #(.AW(AW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // final score selection
    always_comb begin
        priority if (r_zero_q) begin
            w_score = SCORE_ONE;
        end else if (!r_match) begin
            w_score = '0;
        end else if (r_exact) begin
            w_score = SCORE_ONE;
        end else begin
            w_score = w_quot;
        end
    end

    assign w_out_take = r_out_valid && i_m_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= '0;
            r_qa   <= '0;
            r_qb   <= '0;
            r_qc   <= '0;
            r_qd   <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_QLEN) r_qlen <= i_cfg_wdata[5:0];
            if (i_cfg_index == CFG_QA)   r_qa   <= i_cfg_wdata;
            if (i_cfg_index == CFG_QB)   r_qb   <= i_cfg_wdata;
            if (i_cfg_index == CFG_QC)   r_qc   <= i_cfg_wdata;
            if (i_cfg_index == CFG_QD)   r_qd   <= i_cfg_wdata;
        end
    end

    // greedy match and prefix tracking, one character per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_qidx  <= '0;
            r_tpos  <= '0;
            r_run   <= '0;
            r_open  <= 1'b1;
            r_cons  <= '0;
            r_prev  <= '0;
            r_first <= '0;
            r_psum  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.accept && i_char_valid) begin
            if (r_tpos >= TW'(MAX_TARGET)) begin
                r_ovf <= 1'b1;
            end else begin
                if (w_hit) begin
                    if (r_qidx == '0) begin
                        r_first <= r_tpos[PSW-1:0];
                    end else if (32'(r_tpos) == 32'(r_prev) + 32'd1) begin
                        r_cons <= r_cons + 5'd1;
                    end
                    r_prev <= r_tpos[PSW-1:0];
                    r_psum <= r_psum + SW'(r_tpos);
                    r_qidx <= r_qidx + 6'd1;
                end
                if (r_open) begin
                    if ((32'(r_tpos) < 32'(w_qlen)) && (w_ch == w_qc_pos)) begin
                        r_run <= r_run + 6'd1;
                    end else begin
                        r_open <= 1'b0;
                    end
                end
                r_tpos <= r_tpos + TW'(1);
            end
        end
    end

    // score operands, products and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_lm     <= 10'(w_qlen) * 10'(w_m);
            r_rm     <= 10'(w_r) * 10'(w_m);
            r_cl     <= 10'(w_c) * 10'(w_qlen);
            r_sm     <= AMW'(r_psum) * AMW'(w_m);
            r_gd     <= w_gd;
            r_t      <= r_tpos;
            r_multi  <= w_multi;
            r_zero_q <= w_qlen == '0;
            r_match  <= w_match;
            r_exact  <= w_exact;
        end
        if (i_cmd.calc) begin
            r_prod <= w_prod;
            unique case (i_cmd.step.acc_op)
                ACC_NONE: ;
                ACC_INIT: begin
                    r_acc <= w_p * AW'(25);
                    r_den <= w_p * AW'(50);
                end
                ACC_ADD15: r_acc <= r_acc + w_p * AW'(15);
                ACC_ADD7:  if (r_multi) r_acc <= r_acc + w_p * AW'(7);
                ACC_ADD3:  if (r_multi) r_acc <= r_acc + w_p * AW'(3);
                ACC_NEG:   r_num <= (r_acc > w_neg) ? r_acc - w_neg : '0;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_o_matched <= r_zero_q || r_match;
            r_o_score   <= w_score;
            r_o_first   <= (!r_zero_q && r_match) ? 10'(r_first) : 10'd0;
            r_o_last    <= (!r_zero_q && r_match) ? 10'(r_prev) : 10'd0;
            r_o_ovf     <= r_ovf;
        end
    end

    assign o_status.need_calc = (w_qlen != '0) && w_match && !w_exact;
    assign o_status.div_busy  = w_div_busy;
    assign o_status.out_full  = r_out_valid && !i_m_tready;

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_o_matched;
    assign o_score     = r_o_score;
    assign o_first     = r_o_first;
    assign o_last      = r_o_last;
    assign o_overflow  = r_o_ovf;

endmodule

@@ rtl/core/fss_ctrl.sv @@
// ----------------------------------------------------------------------------
// fss_ctrl
// Controller: streams characters, then sequences the score computation
// and the hand-off into the result register.
// ----------------------------------------------------------------------------
module fss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    input  fss_pkg::t_status i_status,
    output fss_pkg::t_cmd    o_cmd
);
    import fss_pkg::*;

    localparam logic [2:0] S_RUN    = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_CALC   = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       w_accept;

    assign o_in_ready = r_state == S_RUN;
    assign w_accept   = o_in_ready && i_in_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.step = step_cmd(r_step);
        unique case (r_state)
            S_RUN: begin
                o_cmd.accept = w_accept;
                if (w_accept && i_in_last) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = i_status.need_calc ? S_CALC : S_DONE;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_step     = r_step + 4'd1;
                if (r_step == LAST_STEP) n_state = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

@@ rtl/core/fuzzy_subsequence_scorer.sv @@
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Case-folded greedy subsequence match of a configured query against a
// streamed target, with a fixed-point score per target.
// ----------------------------------------------------------------------------
// channel   dir  beat                     tdata / tuser
// s_axis    in   one target character     tdata: target_char; tuser: char_valid
// m_axis    out  one result per target    tdata: score, first, last; tuser: flags
// cfg       in   one register write       index 0 length, 1..4 query bytes
//
// Characters are taken one per cycle. After the last character the input
// stalls while the operands are prepared and, when a division is needed, for
// nine steps of the shared multiplier and 16 steps of the bit-serial divider.
// A result waits in the output register; a new target streams in meanwhile,
// and its end stalls only while that register is still full.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer #(
    parameter int MAX_QUERY  = 32,
    parameter int MAX_TARGET = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] target_char
    input  logic        s_axis_tuser,   // [0] char_valid
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [16:0] score, [26:17] first_position,
                                        // [36:27] last_position, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [0] matched, [1] target_overflow
);
    import fss_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_matched, w_ovf;
    logic [16:0] w_score;
    logic [9:0]  w_first, w_last;

    fss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fss_datapath #(
        .MAX_QUERY  (MAX_QUERY),
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char       (s_axis_tdata),
        .i_char_valid (s_axis_tuser),
        .i_m_tready   (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_matched    (w_matched),
        .o_score      (w_score),
        .o_first      (w_first),
        .o_last       (w_last),
        .o_overflow   (w_ovf)
    );

    assign m_axis_tdata = {3'b000, w_last, w_first, w_score};
    assign m_axis_tuser = {w_ovf, w_matched};

endmodule

@@ rtl/core/fss_checker.sv @@
// ----------------------------------------------------------------------------
// fss_props
// Port-level checks of the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module fss_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // end of target stops the input for scoring
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input not stalled after end of target");

    // a new result only appears after the input has been stalled
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without end of target");

    // no match means zero score and positions
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[36:0] == 37'd0)
        else $error("unmatched result with nonzero fields");

    // score never above one
    a_score_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'h10000)
        else $error("score above one");

endmodule

bind fuzzy_subsequence_scorer fss_props u_fss_props (.*);

@@ test/fss_checker.sv @@
// ----------------------------------------------------------------------------
// fss_checker
// Watches the character and result channels and the register writes of the
// fuzzy subsequence scorer, keeps its own match state, and compares every
// result beat with the score expected for the target that ended.
// ----------------------------------------------------------------------------
module fss_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fss_pkg::*;

    localparam int MAXQ = 32;
    localparam int MAXT = 1024;

    typedef struct packed {
        logic        matched;
        logic        overflow;
        logic [16:0] score;
        logic [9:0]  first_pos;
        logic [9:0]  last_pos;
    } t_result;

    // configuration copy
    logic [5:0]  qlen;
    logic [63:0] qwords [4];

    // per-target match state
    int unsigned q_idx, t_pos, p_run, cons, prev_m, first_m, p_sum;
    bit          p_open, ovf;

    t_result score_queue [$];

    function automatic logic [7:0] lower(input logic [7:0] ch);
        return (ch >= 8'd65 && ch <= 8'd90) ? ch + 8'd32 : ch;
    endfunction

    function automatic logic [7:0] query_byte(input int unsigned idx);
        return lower(qwords[(idx >> 3) & 3][(idx & 7) * 8 +: 8]);
    endfunction

    function automatic int unsigned used_len();
        int unsigned n;
        n = qlen;
        if (n > MAXQ) n = MAXQ;
        return n;
    endfunction

    // exact integer form of the weighted score
    function automatic logic [16:0] weighted_score(input int unsigned len,
                                                   input longint unsigned tl);
        longint unsigned r, m, gd, d, pos, neg, num, s, span, g, c;
        r = (p_run < len) ? p_run : len;
        if (tl == len && r == len) return SCORE_ONE;
        m = (len > 1) ? len - 1 : 1;
        gd = 1;
        if (len > 1) begin
            span = prev_m - first_m;
            g = (span > len - 1) ? span - (len - 1) : 0;
            gd = 1 + g;
        end
        d = 5 * len * m * gd * tl;
        pos = 5 * d + 15 * r * m * gd * tl;
        if (len > 1) begin
            c = (cons < len - 1) ? cons : len - 1;
            pos += 7 * c * len * gd * tl;
            pos += 3 * len * m * tl;
        end
        neg = 5 * longint'(p_sum) * m * gd;
        num = (pos > neg) ? pos - neg : 0;
        s = (num * 65536) / (10 * d);
        return (s > 65536) ? SCORE_ONE : 17'(s);
    endfunction

    task automatic clear_match();
        q_idx = 0; t_pos = 0; p_run = 0; p_open = 1; cons = 0;
        prev_m = 0; first_m = 0; p_sum = 0; ovf = 0;
    endtask

    // one accepted character beat
    task automatic take_char(input logic [7:0] raw, input bit valid, input bit last);
        logic [7:0]  ch;
        int unsigned len, p;
        t_result     res;
        ch = lower(raw);
        len = used_len();
        if (valid) begin
            if (t_pos >= MAXT) begin
                ovf = 1;
            end else begin
                p = t_pos;
                if (q_idx < len && ch == query_byte(q_idx)) begin
                    if (q_idx == 0) first_m = p;
                    else if (p == prev_m + 1) cons++;
                    prev_m = p;
                    p_sum += p;
                    q_idx++;
                end
                if (p_open) begin
                    if (p < len && ch == query_byte(p)) p_run++;
                    else p_open = 0;
                end
                t_pos = p + 1;
            end
        end
        if (last) begin
            res = '0;
            if (len == 0) begin
                res.matched = 1;
                res.score = SCORE_ONE;
            end else if (t_pos != 0 && q_idx == len) begin
                res.matched = 1;
                res.first_pos = 10'(first_m);
                res.last_pos = 10'(prev_m);
                res.score = weighted_score(len, t_pos);
            end
            res.overflow = ovf;
            score_queue.push_back(res);
            clear_match();
        end
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_result();
        t_result want, got;
        got.score = i_m_tdata[16:0];
        got.first_pos = i_m_tdata[26:17];
        got.last_pos = i_m_tdata[36:27];
        got.matched = i_m_tuser[0];
        got.overflow = i_m_tuser[1];
        if (score_queue.size() == 0) begin
            $display("%0t: result beat with none expected: %h", $time, got);
            o_errors++;
            return;
        end
        want = score_queue.pop_front();
        if (got.matched !== want.matched) begin
            $display("%0t: matched exp %0d got %0d", $time, want.matched, got.matched);
            o_errors++;
        end
        if (got.score !== want.score) begin
            $display("%0t: score exp %0d got %0d", $time, want.score, got.score);
            o_errors++;
        end
        if (got.first_pos !== want.first_pos) begin
            $display("%0t: first exp %0d got %0d", $time, want.first_pos, got.first_pos);
            o_errors++;
        end
        if (got.last_pos !== want.last_pos) begin
            $display("%0t: last exp %0d got %0d", $time, want.last_pos, got.last_pos);
            o_errors++;
        end
        if (got.overflow !== want.overflow) begin
            $display("%0t: overflow exp %0d got %0d", $time, want.overflow, got.overflow);
            o_errors++;
        end
        if (i_m_tdata[39:37] !== 3'b000) begin
            $display("%0t: pad bits exp 0 got %b", $time, i_m_tdata[39:37]);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        qlen = '0;
        foreach (qwords[k]) qwords[k] = '0;
        clear_match();
    end

    // sample everything at the edge, before the driver's updates land
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qlen = '0;
            foreach (qwords[k]) qwords[k] = '0;
            clear_match();
            score_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_s_tvalid && i_s_tready) take_char(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_QLEN) qlen = i_cfg_wdata[5:0];
                else if (i_cfg_index == CFG_QA) qwords[0] = i_cfg_wdata;
                else if (i_cfg_index == CFG_QB) qwords[1] = i_cfg_wdata;
                else if (i_cfg_index == CFG_QC) qwords[2] = i_cfg_wdata;
                else if (i_cfg_index == CFG_QD) qwords[3] = i_cfg_wdata;
            end
        end
        o_pending = score_queue.size();
    end

endmodule

@@ test/tb_fuzzy_subsequence_scorer.sv @@
// ----------------------------------------------------------------------------
// tb_fuzzy_subsequence_scorer
// Streams targets built around the configured query, mostly real matches
// with random case and fillers, plus noise and overlong targets, under
// random idling on both channels and several query settings.
// ----------------------------------------------------------------------------
module tb_fuzzy_subsequence_scorer;
    timeunit 1ns;
    timeprecision 1ps;
    import fss_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int  errors, pending, beats_sent;
    bit  quiet;
    logic [7:0] query_text [32];
    int  query_len;

    fuzzy_subsequence_scorer dut (.*);

    fss_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_s_tuser(s_axis_tuser), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // result side backpressure in short bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    // drop the character channel while the sender pauses
    task automatic stop_input();
        s_axis_tvalid <= 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        s_axis_tvalid <= 0;
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        @(posedge i_clk);
    endtask

    // wait for every result, then let the back end settle before a write
    task automatic drain();
        stop_input();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // load a query, chars drawn from a small alphabet so matches happen, or random bytes when wild
    task automatic set_query(input int len, input logic [5:0] len_reg, input bit wild);
        logic [63:0] w;
        drain();
        for (int k = 0; k < 32; k++) begin
            if (wild) query_text[k] = 8'($urandom);
            else query_text[k] = 8'("a" + $urandom_range(0, 5));
            if (!wild && $urandom_range(0, 2) == 0) query_text[k] -= 8'd32;
        end
        query_len = len;
        for (int r = 0; r < 4; r++) begin
            for (int b = 0; b < 8; b++) w[b * 8 +: 8] = query_text[r * 8 + b];
            write_reg(3'(CFG_QA + r), w);
        end
        write_reg(CFG_QLEN, 64'(len_reg));
    endtask

    // one character beat, with optional idle burst before it
    task automatic send_char(input logic [7:0] ch, input bit valid, input bit last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= ch;
        s_axis_tuser <= valid;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    function automatic logic [7:0] flip_case(input logic [7:0] ch);
        if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) return ch - 8'd32;
        if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1)) return ch + 8'd32;
        return ch;
    endfunction

    // a target that holds the query as a subsequence, with random fillers
    task automatic send_match(input int gap_max);
        for (int k = 0; k < query_len; k++) begin
            repeat ($urandom_range(0, gap_max)) begin
                send_char(8'("a" + $urandom_range(0, 7)), 1'b1, 1'b0);
            end
            if ($urandom_range(0, 9) == 0) send_char(8'($urandom), 1'b0, 1'b0);
            send_char(flip_case(query_text[k]), 1'b1, 1'b0);
        end
        repeat ($urandom_range(0, gap_max))
            send_char(8'("a" + $urandom_range(0, 7)), 1'b1, 1'b0);
        send_char(flip_case(8'("a" + $urandom_range(0, 7))), 1'($urandom_range(0, 1)),
                  1'b1);
    endtask

    task automatic send_noise(input int len);
        for (int k = 0; k < len; k++)
            send_char(8'($urandom), $urandom_range(0, 5) != 0, 1'b0);
        send_char(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic send_exact();
        for (int k = 0; k < query_len; k++)
            send_char(flip_case(query_text[k]), 1'b1, k == query_len - 1);
        if (query_len == 0) send_char(8'h00, 1'b0, 1'b1);
    endtask

    task automatic random_phase(input int beats);
        int stop, pick;
        stop = beats_sent + beats;
        while (beats_sent < stop) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) send_match($urandom_range(0, 3));
            else if (pick < 8) send_exact();
            else send_noise($urandom_range(0, 12));
        end
    endtask

    initial begin
        beats_sent = 0;
        quiet = 0;
        query_len = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty query, empty targets, extremes of the char byte
        send_char(8'h00, 1'b0, 1'b1);
        send_char(8'hff, 1'b1, 1'b1);
        send_char(8'h41, 1'b1, 1'b0);
        send_char(8'h5a, 1'b1, 1'b1);
        set_query(1, 6'd1, 0);
        send_char(8'h00, 1'b0, 1'b1);
        send_exact();
        send_match(2);
        send_noise(3);
        set_query(32, 6'd63, 1);
        send_exact();
        send_match(1);
        send_noise(4);

        // query edited while a target streams
        set_query(3, 6'd3, 0);
        send_char(query_text[0], 1'b1, 1'b0);
        send_char(query_text[1], 1'b1, 1'b0);
        write_reg(CFG_QLEN, 64'd2);
        send_char(query_text[2], 1'b1, 1'b1);
        drain();
        write_reg(CFG_QLEN, 64'd3);
        query_len = 3;

        // overlong target, every beat but the closing one a character
        for (int k = 0; k < 1030; k++) send_char(8'($urandom), 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b1);

        // random phases over several query settings
        set_query(4, 6'd4, 0);
        random_phase(100);
        set_query(1, 6'd1, 0);
        random_phase(50);
        set_query(32, 6'd32, 0);
        random_phase(120);
        set_query(0, 6'd0, 0);
        random_phase(20);
        set_query(7, 6'd7, 0);
        random_phase(60);

        // sender holds off until all results are in
        stop_input();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        random_phase(40);

        // final stretch without idling
        quiet = 1;
        set_query(5, 6'd5, 0);
        random_phase(60);

        stop_input();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
